[hdl/apbt_pkg.sv]
package apbt_pkg;

  localparam int CoordW = 32;
  localparam int CmdW = 2;
  localparam int RegIdxW = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [CmdW-1:0] cmd_t;
  typedef logic [RegIdxW-1:0] reg_idx_t;

  localparam cmd_t CMD_POINT = 2'd0;
  localparam cmd_t CMD_DIST = 2'd1;
  localparam cmd_t CMD_BBOX = 2'd2;

  localparam reg_idx_t REG_COEF_XX = 3'd0;
  localparam reg_idx_t REG_COEF_YX = 3'd1;
  localparam reg_idx_t REG_COEF_XY = 3'd2;
  localparam reg_idx_t REG_COEF_YY = 3'd3;
  localparam reg_idx_t REG_OFFSET_X = 3'd4;
  localparam reg_idx_t REG_OFFSET_Y = 3'd5;

  localparam coord_t COEF_ONE = 32'sd65536;

  typedef struct packed {
    coord_t coef_xx;
    coord_t coef_yx;
    coord_t coef_xy;
    coord_t coef_yy;
    coord_t offset_x;
    coord_t offset_y;
  } apbt_coef_t;

  typedef struct packed {
    logic bbox;
    logic no_offset;
  } apbt_mode_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic ovf;
  } apbt_corner_t;

  function automatic coord_t coord_min(input coord_t a, input coord_t b);
    return (b < a) ? b : a;
  endfunction

  function automatic coord_t coord_max(input coord_t a, input coord_t b);
    return (b > a) ? b : a;
  endfunction

endpackage

[hdl/affine_point_bbox_transform_unit.sv]
// Affine transform of Q16.16 points, offset-free distances and bounding boxes
// by a six-coefficient matrix held in registers cfg_idx 0..5 (coef_xx, coef_yx,
// coef_xy, coef_yy, offset_x, offset_y). cmd 0 transforms a point, 1 a
// distance (no offset), 2 or 3 the box spanned by two corners, returning
// per-axis min in out_x1/out_y1 and max in out_x2/out_y2. Products truncate
// toward minus infinity; sums saturate to COORD_WIDTH bits (at most 32) and
// set overflow. One item is taken per clock while in_stall is low; each result
// passes four register stages: input register, eight parallel 32x32
// multipliers, three-term add with saturation, min/max selection. Write the
// matrix only while the pipeline is empty.
module affine_point_bbox_transform_unit
  import apbt_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_wr,
  input  reg_idx_t cfg_idx,
  input  coord_t   cfg_data,
  input  logic     in_valid,
  output logic     in_stall,
  input  cmd_t     cmd,
  input  coord_t   in_x1,
  input  coord_t   in_y1,
  input  coord_t   in_x2,
  input  coord_t   in_y2,
  output logic     out_valid,
  input  logic     out_stall,
  output coord_t   out_x1,
  output coord_t   out_y1,
  output coord_t   out_x2,
  output coord_t   out_y2,
  output logic     overflow
);

  localparam int PW = 2 * CoordW - FRAC_BITS;

  apbt_coef_t coef;

  logic s0_valid;
  logic s0_advance;
  apbt_mode_t s0_mode;
  coord_t s0_x1;
  coord_t s0_y1;
  coord_t s0_x2;
  coord_t s0_y2;

  logic mul_stall;
  logic mul_valid;
  apbt_mode_t mul_mode;
  logic signed [PW-1:0] pxx [2];
  logic signed [PW-1:0] pxy [2];
  logic signed [PW-1:0] pyx [2];
  logic signed [PW-1:0] pyy [2];

  logic sum_stall;
  logic sum_valid;
  apbt_mode_t sum_mode;
  apbt_corner_t corner [4];

  logic box_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.coef_xx <= COEF_ONE;
      coef.coef_yx <= '0;
      coef.coef_xy <= '0;
      coef.coef_yy <= COEF_ONE;
      coef.offset_x <= '0;
      coef.offset_y <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_COEF_XX: coef.coef_xx <= cfg_data;
        REG_COEF_YX: coef.coef_yx <= cfg_data;
        REG_COEF_XY: coef.coef_xy <= cfg_data;
        REG_COEF_YY: coef.coef_yy <= cfg_data;
        REG_OFFSET_X: coef.offset_x <= cfg_data;
        REG_OFFSET_Y: coef.offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s0_advance = !s0_valid || !mul_stall;
  assign in_stall = s0_valid && mul_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_advance) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_advance && in_valid) begin
      s0_mode.bbox <= cmd[1];
      s0_mode.no_offset <= (cmd == CMD_DIST);
      s0_x1 <= in_x1;
      s0_y1 <= in_y1;
      s0_x2 <= in_x2;
      s0_y2 <= in_y2;
    end
  end

  apbt_mul_stage #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s0_valid),
    .up_stall (mul_stall),
    .up_mode  (s0_mode),
    .x1       (s0_x1),
    .y1       (s0_y1),
    .x2       (s0_x2),
    .y2       (s0_y2),
    .coef     (coef),
    .valid    (mul_valid),
    .dn_stall (sum_stall),
    .mode     (mul_mode),
    .pxx      (pxx),
    .pxy      (pxy),
    .pyx      (pyx),
    .pyy      (pyy)
  );

  apbt_sum_stage #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_sum (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mul_valid),
    .up_stall (sum_stall),
    .up_mode  (mul_mode),
    .pxx      (pxx),
    .pxy      (pxy),
    .pyx      (pyx),
    .pyy      (pyy),
    .coef     (coef),
    .valid    (sum_valid),
    .dn_stall (box_stall),
    .mode     (sum_mode),
    .corner   (corner)
  );

  apbt_bbox_stage u_box (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sum_valid),
    .up_stall (box_stall),
    .up_mode  (sum_mode),
    .corner   (corner),
    .valid    (out_valid),
    .dn_stall (out_stall),
    .x_lo     (out_x1),
    .y_lo     (out_y1),
    .x_hi     (out_x2),
    .y_hi     (out_y2),
    .ovf      (overflow)
  );

endmodule

[hdl/apbt_mul_stage.sv]
module apbt_mul_stage
  import apbt_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  localparam int PW = 2 * CoordW - FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  apbt_mode_t           up_mode,
  input  coord_t               x1,
  input  coord_t               y1,
  input  coord_t               x2,
  input  coord_t               y2,
  input  apbt_coef_t           coef,
  output logic                 valid,
  input  logic                 dn_stall,
  output apbt_mode_t           mode,
  output logic signed [PW-1:0] pxx [2],
  output logic signed [PW-1:0] pxy [2],
  output logic signed [PW-1:0] pyx [2],
  output logic signed [PW-1:0] pyy [2]
);

  logic advance;
  logic signed [2*CoordW-1:0] mxx [2];
  logic signed [2*CoordW-1:0] mxy [2];
  logic signed [2*CoordW-1:0] myx [2];
  logic signed [2*CoordW-1:0] myy [2];

  assign advance = !valid || !dn_stall;
  assign up_stall = valid && dn_stall;

  always_comb begin
    mxx[0] = coef.coef_xx * x1;
    mxx[1] = coef.coef_xx * x2;
    mxy[0] = coef.coef_xy * y1;
    mxy[1] = coef.coef_xy * y2;
    myx[0] = coef.coef_yx * x1;
    myx[1] = coef.coef_yx * x2;
    myy[0] = coef.coef_yy * y1;
    myy[1] = coef.coef_yy * y2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      mode <= up_mode;
      for (int k = 0; k < 2; k++) begin
        pxx[k] <= PW'(mxx[k] >>> FRAC_BITS);
        pxy[k] <= PW'(mxy[k] >>> FRAC_BITS);
        pyx[k] <= PW'(myx[k] >>> FRAC_BITS);
        pyy[k] <= PW'(myy[k] >>> FRAC_BITS);
      end
    end
  end

endmodule

[hdl/apbt_sum_stage.sv]
module apbt_sum_stage
  import apbt_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16,
  localparam int PW = 2 * CoordW - FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  apbt_mode_t           up_mode,
  input  logic signed [PW-1:0] pxx [2],
  input  logic signed [PW-1:0] pxy [2],
  input  logic signed [PW-1:0] pyx [2],
  input  logic signed [PW-1:0] pyy [2],
  input  apbt_coef_t           coef,
  output logic                 valid,
  input  logic                 dn_stall,
  output apbt_mode_t           mode,
  output apbt_corner_t         corner [4]
);

  localparam int SW = PW + 2;
  localparam int SAT_W = (COORD_WIDTH > CoordW) ? CoordW : COORD_WIDTH;
  localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  logic advance;
  coord_t off_x;
  coord_t off_y;
  apbt_corner_t corner_next [4];

  function automatic logic [CoordW:0] saturate(input logic signed [SW-1:0] s);
    logic [CoordW:0] r;
    if (s > SMAX) begin
      r = {1'b1, CoordW'(SMAX)};
    end else if (s < SMIN) begin
      r = {1'b1, CoordW'(SMIN)};
    end else begin
      r = {1'b0, CoordW'(s)};
    end
    return r;
  endfunction

  assign advance = !valid || !dn_stall;
  assign up_stall = valid && dn_stall;
  assign off_x = up_mode.no_offset ? '0 : coef.offset_x;
  assign off_y = up_mode.no_offset ? '0 : coef.offset_y;

  for (genvar i = 0; i < 4; i++) begin : g_corner
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic [CoordW:0] rx;
    logic [CoordW:0] ry;

    assign sx = SW'(pxx[i % 2]) + SW'(pxy[i / 2]) + SW'(off_x);
    assign sy = SW'(pyx[i % 2]) + SW'(pyy[i / 2]) + SW'(off_y);
    assign rx = saturate(sx);
    assign ry = saturate(sy);
    assign corner_next[i].x = coord_t'(rx[CoordW-1:0]);
    assign corner_next[i].y = coord_t'(ry[CoordW-1:0]);
    assign corner_next[i].ovf = rx[CoordW] | ry[CoordW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      mode <= up_mode;
      for (int k = 0; k < 4; k++) begin
        corner[k] <= corner_next[k];
      end
    end
  end

endmodule

[hdl/apbt_bbox_stage.sv]
module apbt_bbox_stage
  import apbt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         up_valid,
  output logic         up_stall,
  input  apbt_mode_t   up_mode,
  input  apbt_corner_t corner [4],
  output logic         valid,
  input  logic         dn_stall,
  output coord_t       x_lo,
  output coord_t       y_lo,
  output coord_t       x_hi,
  output coord_t       y_hi,
  output logic         ovf
);

  logic advance;
  coord_t x_lo_next;
  coord_t y_lo_next;
  coord_t x_hi_next;
  coord_t y_hi_next;
  logic ovf_next;

  assign advance = !valid || !dn_stall;
  assign up_stall = valid && dn_stall;

  always_comb begin
    if (up_mode.bbox) begin
      x_lo_next = coord_min(coord_min(corner[0].x, corner[1].x),
                            coord_min(corner[2].x, corner[3].x));
      y_lo_next = coord_min(coord_min(corner[0].y, corner[1].y),
                            coord_min(corner[2].y, corner[3].y));
      x_hi_next = coord_max(coord_max(corner[0].x, corner[1].x),
                            coord_max(corner[2].x, corner[3].x));
      y_hi_next = coord_max(coord_max(corner[0].y, corner[1].y),
                            coord_max(corner[2].y, corner[3].y));
      ovf_next = corner[0].ovf | corner[1].ovf | corner[2].ovf | corner[3].ovf;
    end else begin
      x_lo_next = corner[0].x;
      y_lo_next = corner[0].y;
      x_hi_next = '0;
      y_hi_next = '0;
      ovf_next = corner[0].ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      x_lo <= x_lo_next;
      y_lo <= y_lo_next;
      x_hi <= x_hi_next;
      y_hi <= y_hi_next;
      ovf <= ovf_next;
    end
  end

endmodule
